// File: rtl/solr_pkg.sv
// shared types, constants and helpers of the sequenced overwrite log ring
`default_nettype none

package solr_pkg;

   localparam int DEPTH         = 1024;
   localparam int MESSAGE_BYTES = 8;
   localparam int ADDR_W        = $clog2(DEPTH);
   localparam int FILL_W        = $clog2(DEPTH + 1);
   localparam int LEN_W         = 4;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [FILL_W-1:0] fill_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_APP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FETCH
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] app_tag;
      logic [7:0]  level;
      logic [63:0] timestamp;
      logic [63:0] message_word;
      logic [7:0]  message_length;
      logic [63:0] session_tag;
      logic [63:0] last_seen;
   } req_type;

   typedef struct packed {
      logic             entry_found;
      logic [63:0]      entry_sequence;
      logic [63:0]      entry_timestamp;
      logic [7:0]       entry_level;
      logic [31:0]      entry_app;
      logic [63:0]      entry_message;
      logic [LEN_W-1:0] entry_length;
      logic [63:0]      resume_point;
      logic             more_pending;
      logic             truncated;
      logic [63:0]      current_session;
   } rsp_type;

   typedef struct packed {
      logic [63:0]      timestamp;
      logic [63:0]      message;
      logic [7:0]       level;
      logic [31:0]      app;
      logic [LEN_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      entry_type wr_data;
      logic      rd_en;
      addr_type  rd_addr;
   } ram_req_type;

   // ring index wrap for a sum of two indexes below DEPTH
   function automatic addr_type wrap_addr(input logic [ADDR_W:0] sum);
      logic [ADDR_W:0] fixed;
      if (sum >= (ADDR_W + 1)'(DEPTH)) begin
         fixed = sum - (ADDR_W + 1)'(DEPTH);
      end else begin
         fixed = sum;
      end
      return fixed[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/solr_entry_ram.sv
// entry memory: one write port, one registered read port
`default_nettype none

module solr_entry_ram (
   input  wire logic                clock,
   input  wire solr_pkg::ram_req_type ram_req,
   output solr_pkg::entry_type      rd_data
);
   import solr_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/solr_ring_ctrl.sv
// ring pointers, session state and read lookup sequencer
`default_nettype none

module solr_ring_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire solr_pkg::req_type   req_data,
   output logic                     req_stall,
   output solr_pkg::ram_req_type    ram_req,
   input  wire solr_pkg::entry_type ram_rd_data,
   input  wire logic                out_free,
   output logic                     rsp_load,
   output solr_pkg::rsp_type        rsp_word
);
   import solr_pkg::*;

   state_type   state_ff, state_in;
   addr_type    oldest_index_ff, oldest_index_in;
   fill_type    fill_ff, fill_in;
   logic [63:0] oldest_num_ff, oldest_num_in;
   logic [63:0] session_ff, session_in;
   logic [63:0] generation_ff, generation_in;
   logic [31:0] active_app_ff, active_app_in;

   logic [63:0] req_session_ff, req_after_ff;
   logic        found_ff, more_ff, trunc_ff;
   logic [63:0] seq_ff, cursor_ff;

   logic             accept;
   logic             is_idle, is_calc;
   logic [LEN_W-1:0] len_sat;
   logic [63:0]      msg_masked;
   addr_type         wr_slot;
   logic             full;

   logic [63:0] cursor, diff, seq;
   logic        lt, empty, found, more, trunc;
   fill_type    fill_m1, offset;
   addr_type    rd_slot;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.command == CMD_READ) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      is_idle  = 1'b0;
      is_calc  = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE:  is_idle  = 1'b1;
         ST_CALC:  is_calc  = 1'b1;
         ST_FETCH: rsp_load = out_free;
         default: begin
            is_idle = 1'b0;
         end
      endcase
   end

   assign req_stall = !is_idle;
   assign accept    = req_valid && is_idle;

   // write word formatting
   always_comb begin
      if (req_data.message_length > 8'(MESSAGE_BYTES)) begin
         len_sat = LEN_W'(MESSAGE_BYTES);
      end else begin
         len_sat = req_data.message_length[LEN_W-1:0];
      end
      for (int b = 0; b < 8; b++) begin
         msg_masked[b*8 +: 8] = (b < int'(len_sat)) ? req_data.message_word[b*8 +: 8] : 8'h00;
      end
   end

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign wr_slot = full ? oldest_index_ff
                         : wrap_addr((ADDR_W + 1)'(oldest_index_ff)
                                     + (ADDR_W + 1)'(fill_ff[ADDR_W-1:0]));

   // ring state update
   always_comb begin
      oldest_index_in = oldest_index_ff;
      fill_in         = fill_ff;
      oldest_num_in   = oldest_num_ff;
      session_in      = session_ff;
      generation_in   = generation_ff;
      active_app_in   = active_app_ff;
      if (accept) begin
         case (req_data.command)
            CMD_WRITE: begin
               if (full) begin
                  oldest_index_in = wrap_addr((ADDR_W + 1)'(oldest_index_ff) + 1'b1);
                  oldest_num_in   = oldest_num_ff + 64'd1;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
            CMD_RESET: begin
               if (req_data.session_tag != session_ff) begin
                  oldest_index_in = '0;
                  fill_in         = '0;
                  oldest_num_in   = 64'd1;
                  session_in      = req_data.session_tag;
               end
            end
            CMD_APP: begin
               if (req_data.app_tag == 32'd0) begin
                  active_app_in = 32'd0;
               end else if (req_data.app_tag != active_app_ff) begin
                  oldest_index_in = '0;
                  fill_in         = '0;
                  oldest_num_in   = 64'd1;
                  generation_in   = generation_ff + 64'd1;
                  session_in      = generation_ff + 64'd1;
                  active_app_in   = req_data.app_tag;
               end
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   // read lookup, from the registered cursor and session tag
   always_comb begin
      cursor  = (req_session_ff == session_ff) ? req_after_ff : 64'd0;
      lt      = cursor < oldest_num_ff;
      diff    = cursor - oldest_num_ff;
      empty   = (fill_ff == '0);
      fill_m1 = fill_ff - 1'b1;
      found   = !empty && (lt || diff < 64'(fill_m1));
      offset  = lt ? '0 : diff[FILL_W-1:0] + 1'b1;
      more    = (offset + 1'b1) < fill_ff;
      trunc   = !empty && lt && (diff != '1);
      seq     = lt ? oldest_num_ff : cursor + 64'd1;
      rd_slot = wrap_addr((ADDR_W + 1)'(oldest_index_ff)
                          + (ADDR_W + 1)'(offset[ADDR_W-1:0]));
   end

   always_comb begin
      ram_req.wr_en             = accept && req_data.command == CMD_WRITE;
      ram_req.wr_addr           = wr_slot;
      ram_req.wr_data.timestamp = req_data.timestamp;
      ram_req.wr_data.message   = msg_masked;
      ram_req.wr_data.level     = req_data.level;
      ram_req.wr_data.app       = req_data.app_tag;
      ram_req.wr_data.length    = len_sat;
      ram_req.rd_en             = is_calc && found;
      ram_req.rd_addr           = rd_slot;
   end

   always_comb begin
      rsp_word                 = '0;
      rsp_word.entry_found     = found_ff;
      rsp_word.resume_point    = found_ff ? seq_ff : cursor_ff;
      rsp_word.truncated       = trunc_ff;
      rsp_word.current_session = session_ff;
      if (found_ff) begin
         rsp_word.entry_sequence  = seq_ff;
         rsp_word.entry_timestamp = ram_rd_data.timestamp;
         rsp_word.entry_level     = ram_rd_data.level;
         rsp_word.entry_app       = ram_rd_data.app;
         rsp_word.entry_message   = ram_rd_data.message;
         rsp_word.entry_length    = ram_rd_data.length;
         rsp_word.more_pending    = more_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         oldest_index_ff <= '0;
         fill_ff         <= '0;
         oldest_num_ff   <= 64'd1;
         session_ff      <= '0;
         generation_ff   <= '0;
         active_app_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         oldest_index_ff <= oldest_index_in;
         fill_ff         <= fill_in;
         oldest_num_ff   <= oldest_num_in;
         session_ff      <= session_in;
         generation_ff   <= generation_in;
         active_app_ff   <= active_app_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_session_ff <= req_data.session_tag;
         req_after_ff   <= req_data.last_seen;
      end
      if (is_calc) begin
         found_ff  <= found;
         more_ff   <= more;
         trunc_ff  <= trunc;
         seq_ff    <= seq;
         cursor_ff <= cursor;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sequenced_overwrite_log_ring.sv
// top level of the sequenced overwrite log ring: trace ring with read-after-cursor lookup
//
// req channel carries one command word: write entry, read after cursor, reset session
// or application change. rsp channel returns one word per read command and nothing
// for the other commands. both channels use valid/stall; a word moves on a rising
// edge with valid high and stall low.
// writes, session resets and application changes leave the sequencer idle, so a new
// word can be accepted on the next edge. a read passes a lookup state that finds the ring
// slot after the cursor and starts the registered memory read, then a fetch state in
// which the response word is loaded into the output register and req_stall drops.
// rsp_valid rises when that word is loaded; the next word goes in once req_stall drops.
// the single entry memory has one write port and one read port.
// the response sits in an output register; while rsp_stall holds it any next command
// is still taken, but a further read then waits in its fetch cycle with req_stall
// high, so nothing more is taken until the register frees.
// reset (synchronous) empties the ring, sets the next sequence number to 1 and
// clears session tag, generation and active application. entry memory contents are
// not cleared; only filled slots are ever read, so no clearing pass is needed.
`default_nettype none

module sequenced_overwrite_log_ring (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire solr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output solr_pkg::rsp_type      rsp_data
);
   import solr_pkg::*;

   ram_req_type ram_req;
   entry_type   ram_rd_data;
   logic        out_free;
   logic        rsp_load;
   rsp_type     rsp_word;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // pointers, sequence bookkeeping and the read sequencer
   solr_ring_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_word    (rsp_word)
   );

   // entry storage: timestamp, message, level, app and length per slot
   solr_entry_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // output register frees when empty or when its word is taken this edge
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
